FILE: sv/serial_line_editor_core_defines.svh
// ----------------------------------------------------------------------------
// Serial line editor assertion macros
// Shared property forms for the editor's checker.
// ----------------------------------------------------------------------------
`ifndef SERIAL_LINE_EDITOR_CORE_DEFINES_SVH
`define SERIAL_LINE_EDITOR_CORE_DEFINES_SVH

// same-cycle implication, held off during reset
`define SLE_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("serial line editor check failed");

// next-cycle implication, held off during reset
`define SLE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("serial line editor check failed");

`endif

FILE: sv/sle_pkg.sv
// ----------------------------------------------------------------------------
// Serial line editor package
// Types, character codes and status codes shared by the editor modules.
// ----------------------------------------------------------------------------
package sle_pkg;

  localparam int BUFFER_DEPTH = 256;
  localparam int ADDR_W       = $clog2(BUFFER_DEPTH);
  localparam int COUNT_W      = 9;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

  localparam logic [COUNT_W-1:0] LIMIT_RESET = COUNT_W'(200);
  localparam logic [COUNT_W-1:0] LIMIT_MIN   = COUNT_W'(2);
  localparam logic [COUNT_W-1:0] LIMIT_MAX   = COUNT_W'(BUFFER_DEPTH);

  localparam logic [7:0] CH_CTRLQ = 8'h11;
  localparam logic [7:0] CH_CTRLS = 8'h13;
  localparam logic [7:0] CH_DEL   = 8'h7F;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic OP_CHAR = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [1:0] ST_PENDING = 2'd0;
  localparam logic [1:0] ST_ENDED   = 2'd1;
  localparam logic [1:0] ST_CANCEL  = 2'd2;
  localparam logic [1:0] ST_READ    = 2'd3;

  typedef struct packed {
    logic       op;
    logic [7:0] char_in;
    logic [7:0] read_index;
  } sle_in_t;

  typedef struct packed {
    logic       echo_valid;
    logic [7:0] echo_byte;
    logic [1:0] line_status;
    logic [7:0] line_length;
    logic [7:0] read_data;
    logic       last;
  } sle_out_t;

  // one classified item: erase expands to backspace, space, backspace
  typedef struct packed {
    logic       erase;
    logic       echo_valid;
    logic [7:0] echo_byte;
    logic [1:0] line_status;
    logic [7:0] line_length;
    logic [7:0] read_data;
  } sle_cmd_t;

endpackage

FILE: sv/serial_line_editor_core.sv
// ----------------------------------------------------------------------------
// Serial line editor core
// Terminal line editing with echo, erase, cancel and line readback.
// ----------------------------------------------------------------------------
// An item enters every cycle while the command queue has room. Each item
// yields one result beat, except an erase on a non-empty line, which yields
// three (backspace, space, backspace); the back end sends one beat a cycle
// while the output is ready. The first result of an item passes through
// classify and store access, the queue and the output register. A read
// returns the line store as left by all earlier items. The line store needs
// no clearing after reset; the configuration port is always ready and must
// be written only while idle.
module serial_line_editor_core import sle_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [COUNT_W-1:0] cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  sle_in_t            in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output sle_out_t           out_item
);

  logic     f_valid;
  logic     f_ready;
  sle_cmd_t f_cmd;
  logic     q_valid;
  logic     q_ready;
  sle_cmd_t q_cmd;

  assign cfg_ready = 1'b1;

  sle_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .cmd_valid (f_valid),
    .cmd_ready (f_ready),
    .cmd       (f_cmd)
  );

  sle_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_cmd),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_cmd)
  );

  sle_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (q_valid),
    .cmd_ready (q_ready),
    .cmd       (q_cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

FILE: sv/sle_front.sv
// ----------------------------------------------------------------------------
// Serial line editor front end
// Accepts items, keeps the line store and count, and classifies each item.
// ----------------------------------------------------------------------------
module sle_front import sle_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  input  logic [COUNT_W-1:0] cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  sle_in_t            in_item,
  output logic               cmd_valid,
  input  logic               cmd_ready,
  output sle_cmd_t           cmd
);

  logic [7:0]         line_store [BUFFER_DEPTH];
  logic [COUNT_W-1:0] line_limit;
  logic [COUNT_W-1:0] char_count;
  logic [COUNT_W-1:0] char_count_next;
  logic [COUNT_W-1:0] lim_eff;
  logic [COUNT_W-1:0] end_at;
  logic [COUNT_W-1:0] cnt_dec;
  logic [COUNT_W-1:0] cnt_dec2;
  logic [COUNT_W-1:0] cnt_inc;
  logic [COUNT_W-1:0] pos_end;
  logic [7:0]         ch;
  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  logic [7:0]         wr_data;
  logic [7:0]         rd_data;
  logic               accept;
  sle_cmd_t           cmd_new;
  sle_cmd_t           stg_cmd;
  logic               stg_valid;
  logic               stg_read;

  assign accept   = in_valid && in_ready;
  assign in_ready = !stg_valid || cmd_ready;

  always_comb begin
    if (line_limit < LIMIT_MIN) begin
      lim_eff = LIMIT_MIN;
    end else if (line_limit > LIMIT_MAX) begin
      lim_eff = LIMIT_MAX;
    end else begin
      lim_eff = line_limit;
    end
  end

  assign end_at   = lim_eff - COUNT_W'(1);
  assign cnt_dec  = char_count - COUNT_W'(1);
  assign cnt_dec2 = char_count - COUNT_W'(2);
  assign cnt_inc  = char_count + COUNT_W'(1);
  assign pos_end  = (char_count == '0) ? '0 : cnt_dec;
  assign ch       = (in_item.char_in == CH_CR) ? CH_LF : in_item.char_in;

  always_comb begin
    cmd_new         = '0;
    char_count_next = char_count;
    wr_en           = 1'b0;
    wr_addr         = char_count[ADDR_W-1:0];
    wr_data         = '0;
    if (in_item.op == OP_READ) begin
      cmd_new.line_status = ST_READ;
    end else if (ch == CH_BS || ch == CH_DEL) begin
      if (char_count != '0) begin
        cmd_new.erase      = 1'b1;
        cmd_new.echo_valid = 1'b1;
        cmd_new.echo_byte  = CH_BS;
        if (cnt_dec < end_at) begin
          char_count_next = cnt_dec;
        end else begin
          // limit was lowered: erasing still ends the line
          wr_en               = 1'b1;
          wr_addr             = cnt_dec2[ADDR_W-1:0];
          char_count_next     = '0;
          cmd_new.line_status = ST_ENDED;
          cmd_new.line_length = cnt_dec2[7:0];
        end
      end
    end else if (ch == CH_ESC) begin
      wr_en               = 1'b1;
      wr_addr             = '0;
      char_count_next     = '0;
      cmd_new.echo_valid  = 1'b1;
      cmd_new.echo_byte   = CH_CR;
      cmd_new.line_status = ST_CANCEL;
    end else if (ch == CH_CTRLQ || ch == CH_CTRLS) begin
      if (char_count >= end_at) begin
        wr_en               = 1'b1;
        wr_addr             = pos_end[ADDR_W-1:0];
        char_count_next     = '0;
        cmd_new.line_status = ST_ENDED;
        cmd_new.line_length = pos_end[7:0];
      end
    end else begin
      cmd_new.echo_valid = 1'b1;
      cmd_new.echo_byte  = ch;
      wr_en              = 1'b1;
      if (cnt_inc < end_at && ch != CH_LF) begin
        wr_data         = ch;
        char_count_next = cnt_inc;
      end else begin
        // terminator (zero) is stored in place of the character
        char_count_next     = '0;
        cmd_new.line_status = ST_ENDED;
        cmd_new.line_length = char_count[7:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_limit <= LIMIT_RESET;
      char_count <= '0;
      stg_valid  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        line_limit <= cfg_data;
      end
      if (accept) begin
        char_count <= char_count_next;
        stg_valid  <= 1'b1;
      end else if (cmd_ready) begin
        stg_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && wr_en) begin
      line_store[wr_addr] <= wr_data;
    end
    if (accept) begin
      rd_data  <= line_store[in_item.read_index[ADDR_W-1:0]];
      stg_cmd  <= cmd_new;
      stg_read <= (in_item.op == OP_READ);
    end
  end

  assign cmd_valid = stg_valid;

  always_comb begin
    cmd           = stg_cmd;
    cmd.read_data = stg_read ? rd_data : 8'd0;
  end

endmodule

FILE: sv/sle_queue.sv
// ----------------------------------------------------------------------------
// Serial line editor command queue
// Short FIFO that decouples classification from result expansion.
// ----------------------------------------------------------------------------
module sle_queue import sle_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push_valid,
  output logic     push_ready,
  input  sle_cmd_t push_data,
  output logic     pop_valid,
  input  logic     pop_ready,
  output sle_cmd_t pop_data
);

  sle_cmd_t            entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QPTR_W:0]     fill;
  logic                push;
  logic                pop;

  assign push_ready = (fill != (QPTR_W+1)'(QUEUE_DEPTH));
  assign pop_valid  = (fill != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + (QPTR_W+1)'(1);
      end else if (pop && !push) begin
        fill <= fill - (QPTR_W+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

FILE: sv/sle_back.sv
// ----------------------------------------------------------------------------
// Serial line editor back end
// Expands each command into one or three result beats.
// ----------------------------------------------------------------------------
module sle_back import sle_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     cmd_valid,
  output logic     cmd_ready,
  input  sle_cmd_t cmd,
  output logic     out_valid,
  input  logic     out_ready,
  output sle_out_t out_item
);

  sle_cmd_t   cur;
  logic       cur_valid;
  logic [1:0] beat;
  logic       final_beat;
  logic       fire;
  logic       take;

  localparam logic [1:0] BEAT_LAST_ERASE = 2'd2;
  localparam logic [1:0] BEAT_SPACE      = 2'd1;

  assign final_beat = !cur.erase || (beat == BEAT_LAST_ERASE);
  assign fire       = cur_valid && out_ready;
  assign take       = !cur_valid || (fire && final_beat);
  assign cmd_ready  = take;
  assign out_valid  = cur_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      beat      <= '0;
    end else if (take) begin
      cur_valid <= cmd_valid;
      beat      <= '0;
    end else if (fire) begin
      beat <= beat + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cur <= cmd;
    end
  end

  always_comb begin
    out_item            = '0;
    out_item.echo_valid = cur.echo_valid;
    out_item.echo_byte  = (cur.erase && beat == BEAT_SPACE) ? CH_SPACE : cur.echo_byte;
    out_item.last       = final_beat;
    if (final_beat) begin
      out_item.line_status = cur.line_status;
      out_item.line_length = cur.line_length;
      out_item.read_data   = cur.read_data;
    end
  end

endmodule

FILE: sv/sle_checker.sv
// ----------------------------------------------------------------------------
// Serial line editor checker
// Port-level checks on the result stream, bound to the core.
// ----------------------------------------------------------------------------
`include "serial_line_editor_core_defines.svh"

module sle_checker import sle_pkg::*; (
  input logic     clk,
  input logic     rst,
  input logic     out_valid,
  input logic     out_ready,
  input sle_out_t out_item
);

  `SLE_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_item))
  `SLE_ASSERT_NOW(a_status_on_last, clk, rst, out_valid && out_item.line_status != ST_PENDING, out_item.last)
  `SLE_ASSERT_NOW(a_quiet_echo, clk, rst, out_valid && !out_item.echo_valid, out_item.echo_byte == 8'd0)
  `SLE_ASSERT_NOW(a_length_on_end, clk, rst, out_valid && out_item.line_status != ST_ENDED, out_item.line_length == 8'd0)

endmodule

bind serial_line_editor_core sle_checker u_sle_checker (.*);
